[design/gdcr_pkg.sv]
// Shared types and fixed-point constants of the grid DDA column raycaster.
`timescale 1ns / 1ps

package gdcr_pkg;

  // Fixed-point format and screen limit.
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SCREEN = 2048;

  // Field widths.
  localparam int POS_W  = 21;
  localparam int VEC_W  = 18;
  localparam int SCR_W  = 12;
  localparam int COL_W  = 11;
  localparam int CELL_W = 5;
  localparam int VAL_W  = 8;

  // Datapath widths.
  localparam int NUM_W   = 2 * FRAC_BITS + 1;   // divider dividend and quotient
  localparam int CAM_W   = 30;                  // camera x, signed
  localparam int PROD_W  = VEC_W + CAM_W;       // plane times camera x
  localparam int RD_W    = 34;                  // ray direction, signed
  localparam int DLT_W   = FRAC_BITS + 16;      // delta, saturated to 2^(F+15)
  localparam int FSEL_W  = FRAC_BITS + 1;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 40;

  localparam logic [NUM_W-1:0] DELTA_SAT = NUM_W'(1) << (FRAC_BITS + 15);
  localparam logic [FSEL_W-1:0] ONE_FX   = FSEL_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5,
    CFG_WIDTH   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CAM,
    S_RAY,
    S_RD,
    S_DLT,
    S_SIDE,
    S_START,
    S_STEP,
    S_CHK,
    S_TEST,
    S_PERP,
    S_LINE,
    S_LDIV,
    S_SPAN
  } state_e;

endpackage

[design/grid_dda_column_raycaster_top.sv]
// Column raycaster: map store, ray setup, DDA walk and wall span, with a shared divider.
// Operation: a cell write is a single map write. A cast runs up to four divisions
//   (camera x, two deltas, line height; zero directions and distances skip theirs),
//   setup, and up to 66 DDA steps through STEP, CHK and TEST, one map read each.
// A cast holds off new items until its span is registered, paced by the radix-2 divider.
// Reset: registers take their documented values and a clearing pass writes zero to
//   every map cell, during which no item is accepted.
`timescale 1ns / 1ps

module grid_dda_column_raycaster_top #(
  parameter int MAP_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // column[10:0], cell_x[15:11], cell_y[20:16], cell_value[28:21], zero pad
  input  logic [31:0] s_axis_tdata_i,
  // mode[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_column[10:0], draw_start[21:11], draw_end[32:22], hit_side[33],
  // left_map[34], zero pad
  output logic [39:0] m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_wdata_i
);

  localparam int F         = gdcr_pkg::FRAC_BITS;
  localparam int NW        = gdcr_pkg::NUM_W;
  localparam int CB        = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int CW        = CB + 2;
  localparam int DEPTH     = MAP_SIZE * MAP_SIZE;
  localparam int AW        = $clog2(DEPTH);
  localparam int MAX_STEPS = 2 * MAP_SIZE + 2;
  localparam int IW        = $clog2(MAX_STEPS + 1);
  localparam int SDW       = 33 + IW;

  // Configuration registers
  logic [gdcr_pkg::POS_W-1:0]        pos_x_q, pos_y_q;
  logic signed [gdcr_pkg::VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [gdcr_pkg::SCR_W-1:0]        scr_w_q, scr_h_q;
  logic [gdcr_pkg::SCR_W-1:0]        w_eff, h_eff;

  gdcr_pkg::state_e state_q, state_d;

  // Map store
  logic [gdcr_pkg::VAL_W-1:0] map_mem [DEPTH];
  logic [gdcr_pkg::VAL_W-1:0] mem_rdata_q, mem_wdata;
  logic [AW-1:0]              mem_waddr, mem_raddr, clr_addr_q;
  logic                       mem_we;

  // Input fields
  logic                        in_fire, in_mode, wr_in_map;
  logic [gdcr_pkg::COL_W-1:0]  in_col;
  logic [gdcr_pkg::CELL_W-1:0] in_cx, in_cy;
  logic [gdcr_pkg::VAL_W-1:0]  in_val;

  // Ray state
  logic [gdcr_pkg::COL_W-1:0]         col_q;
  logic signed [gdcr_pkg::CAM_W-1:0]  cam_q;
  logic signed [gdcr_pkg::PROD_W-1:0] prod_q;
  logic signed [gdcr_pkg::RD_W-1:0]   rd_x_q, rd_y_q, rd_sum, rd_cur;
  logic [gdcr_pkg::RD_W-1:0]          rd_mag;
  logic [gdcr_pkg::DLT_W-1:0]         dlt_x_q, dlt_y_q, dlt_cur, dlt_clamp;
  logic [SDW-1:0]                     sd_x_q, sd_y_q, sd_init;
  logic [gdcr_pkg::FSEL_W-1:0]        fsel;
  logic [gdcr_pkg::FRAC_BITS-1:0]     frac_cur;
  logic [gdcr_pkg::FSEL_W+gdcr_pkg::DLT_W-1:0] side_prod;
  logic                               axis_q, side_q, left_q;
  logic signed [CW-1:0]               cell_x_q, cell_y_q;
  logic                               cell_out, start_out;
  logic [IW-1:0]                      iter_q;
  logic [SDW-1:0]                     perp_q;
  logic [NW-1:0]                      line_q;

  // Divider
  logic           div_start, div_busy_q, div_ge;
  logic [5:0]     div_cnt_q;
  logic [NW-1:0]  div_quo_q, div_num, div_quo_n;
  logic [SDW:0]   div_rem_q, div_rem_sh, div_rem_n;
  logic [SDW-1:0] div_den_q, div_den;

  // Output register
  logic                       out_valid_q, out_free;
  logic [gdcr_pkg::COL_W-1:0] out_col_q, out_start_q, out_end_q;
  logic                       out_side_q, out_left_q;
  logic [NW-1:0]              half, hh, span_start, span_end_sum, span_end;

  assign cfg_ready_o = 1'b1;

  assign w_eff = (scr_w_q == '0) ? gdcr_pkg::SCR_W'(1) :
                 (scr_w_q > gdcr_pkg::SCR_W'(gdcr_pkg::MAX_SCREEN)) ?
                 gdcr_pkg::SCR_W'(gdcr_pkg::MAX_SCREEN) : scr_w_q;
  assign h_eff = (scr_h_q == '0) ? gdcr_pkg::SCR_W'(1) :
                 (scr_h_q > gdcr_pkg::SCR_W'(gdcr_pkg::MAX_SCREEN)) ?
                 gdcr_pkg::SCR_W'(gdcr_pkg::MAX_SCREEN) : scr_h_q;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode   = s_axis_tuser_i;
  assign in_col    = s_axis_tdata_i[10:0];
  assign in_cx     = s_axis_tdata_i[15:11];
  assign in_cy     = s_axis_tdata_i[20:16];
  assign in_val    = s_axis_tdata_i[28:21];
  assign wr_in_map = (32'(in_cx) < 32'(MAP_SIZE)) && (32'(in_cy) < 32'(MAP_SIZE));

  // Ray direction for the axis in hand: dir + floor(plane * cam / 2^F)
  assign rd_sum  = gdcr_pkg::RD_W'(axis_q ? dir_y_q : dir_x_q) +
                   gdcr_pkg::RD_W'(prod_q >>> F);
  assign rd_mag  = rd_sum[gdcr_pkg::RD_W-1] ? gdcr_pkg::RD_W'(-rd_sum)
                                            : gdcr_pkg::RD_W'(rd_sum);
  assign rd_cur  = axis_q ? rd_y_q : rd_x_q;
  assign dlt_cur = axis_q ? dlt_y_q : dlt_x_q;
  assign dlt_clamp = (div_quo_q > gdcr_pkg::DELTA_SAT) ?
                     gdcr_pkg::DLT_W'(gdcr_pkg::DELTA_SAT) : gdcr_pkg::DLT_W'(div_quo_q);

  // Initial side distance: cell fraction towards the step direction times delta
  assign frac_cur  = axis_q ? pos_y_q[F-1:0] : pos_x_q[F-1:0];
  assign fsel      = rd_cur[gdcr_pkg::RD_W-1] ? gdcr_pkg::FSEL_W'(frac_cur)
                                              : gdcr_pkg::ONE_FX - gdcr_pkg::FSEL_W'(frac_cur);
  assign side_prod = fsel * dlt_cur;
  assign sd_init   = SDW'(side_prod >> F);

  assign start_out = (32'(pos_x_q[gdcr_pkg::POS_W-1:F]) >= 32'(MAP_SIZE)) ||
                     (32'(pos_y_q[gdcr_pkg::POS_W-1:F]) >= 32'(MAP_SIZE));
  assign cell_out  = cell_x_q[CW-1] || cell_y_q[CW-1] ||
                     (cell_x_q >= $signed(CW'(MAP_SIZE))) ||
                     (cell_y_q >= $signed(CW'(MAP_SIZE)));
  assign mem_raddr = cell_out ? '0 :
                     AW'(int'(cell_x_q[CB-1:0]) * MAP_SIZE + int'(cell_y_q[CB-1:0]));

  // Divider step: restoring, one quotient bit a cycle
  assign div_rem_sh = {div_rem_q[SDW-1:0], div_quo_q[NW-1]};
  assign div_ge     = div_rem_sh >= {1'b0, div_den_q};
  assign div_rem_n  = div_ge ? div_rem_sh - {1'b0, div_den_q} : div_rem_sh;
  assign div_quo_n  = {div_quo_q[NW-2:0], div_ge};

  // Span around the screen centre
  assign half         = line_q >> 1;
  assign hh           = NW'(h_eff >> 1);
  assign span_start   = (half >= hh) ? '0 : hh - half;
  assign span_end_sum = hh + half;
  assign span_end     = (span_end_sum > NW'(h_eff - gdcr_pkg::SCR_W'(1))) ?
                        NW'(h_eff - gdcr_pkg::SCR_W'(1)) : span_end_sum;
  assign out_free     = !out_valid_q || m_axis_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gdcr_pkg::S_CLEAR: begin
        if (clr_addr_q == AW'(DEPTH - 1)) state_d = gdcr_pkg::S_IDLE;
      end
      gdcr_pkg::S_IDLE: begin
        if (in_fire && in_mode) state_d = gdcr_pkg::S_CAM;
      end
      gdcr_pkg::S_CAM: begin
        if (!div_busy_q) state_d = gdcr_pkg::S_RAY;
      end
      gdcr_pkg::S_RAY:   state_d = gdcr_pkg::S_RD;
      gdcr_pkg::S_RD: begin
        state_d = (rd_mag == '0) ? gdcr_pkg::S_SIDE : gdcr_pkg::S_DLT;
      end
      gdcr_pkg::S_DLT: begin
        if (!div_busy_q) state_d = gdcr_pkg::S_SIDE;
      end
      gdcr_pkg::S_SIDE: begin
        state_d = axis_q ? gdcr_pkg::S_START : gdcr_pkg::S_RAY;
      end
      gdcr_pkg::S_START: begin
        state_d = start_out ? gdcr_pkg::S_LINE : gdcr_pkg::S_STEP;
      end
      gdcr_pkg::S_STEP:  state_d = gdcr_pkg::S_CHK;
      gdcr_pkg::S_CHK: begin
        state_d = cell_out ? gdcr_pkg::S_PERP : gdcr_pkg::S_TEST;
      end
      gdcr_pkg::S_TEST: begin
        if (mem_rdata_q != '0 || iter_q == IW'(MAX_STEPS)) state_d = gdcr_pkg::S_PERP;
        else state_d = gdcr_pkg::S_STEP;
      end
      gdcr_pkg::S_PERP:  state_d = gdcr_pkg::S_LINE;
      gdcr_pkg::S_LINE: begin
        state_d = (perp_q == '0) ? gdcr_pkg::S_SPAN : gdcr_pkg::S_LDIV;
      end
      gdcr_pkg::S_LDIV: begin
        if (!div_busy_q) state_d = gdcr_pkg::S_SPAN;
      end
      gdcr_pkg::S_SPAN: begin
        if (out_free) state_d = gdcr_pkg::S_IDLE;
      end
      default: state_d = gdcr_pkg::S_IDLE;
    endcase
  end

  // Control outputs: handshake, map write port, divider launch
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = clr_addr_q;
    mem_wdata       = '0;
    div_start       = 1'b0;
    div_num         = '0;
    div_den         = '0;
    case (state_q)
      gdcr_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      gdcr_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_fire && !in_mode && wr_in_map) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(int'(in_cx) * MAP_SIZE + int'(in_cy));
          mem_wdata = in_val;
        end
        if (in_fire && in_mode) begin
          div_start = 1'b1;
          div_num   = NW'(in_col) << (F + 1);
          div_den   = SDW'(w_eff);
        end
      end
      gdcr_pkg::S_RD: begin
        if (rd_mag != '0) begin
          div_start = 1'b1;
          div_num   = NW'(1) << (2 * F);
          div_den   = SDW'(rd_mag);
        end
      end
      gdcr_pkg::S_LINE: begin
        if (perp_q != '0) begin
          div_start = 1'b1;
          div_num   = NW'(h_eff) << F;
          div_den   = perp_q;
        end
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // Map store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= map_mem[mem_raddr];
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdcr_pkg::S_CLEAR;
      clr_addr_q  <= '0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pos_x_q     <= gdcr_pkg::POS_W'(98304);
      pos_y_q     <= gdcr_pkg::POS_W'(98304);
      dir_x_q     <= -gdcr_pkg::VEC_W'(65536);
      dir_y_q     <= '0;
      plane_x_q   <= '0;
      plane_y_q   <= gdcr_pkg::VEC_W'(43253);
      scr_w_q     <= gdcr_pkg::SCR_W'(640);
      scr_h_q     <= gdcr_pkg::SCR_W'(480);
    end else begin
      state_q <= state_d;
      if (state_q == gdcr_pkg::S_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 6'(NW);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd1) div_busy_q <= 1'b0;
      end
      if (state_q == gdcr_pkg::S_SPAN && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (gdcr_pkg::cfg_reg_e'(cfg_index_i))
          gdcr_pkg::CFG_POS_X:   pos_x_q   <= cfg_wdata_i;
          gdcr_pkg::CFG_POS_Y:   pos_y_q   <= cfg_wdata_i;
          gdcr_pkg::CFG_DIR_X:   dir_x_q   <= cfg_wdata_i[gdcr_pkg::VEC_W-1:0];
          gdcr_pkg::CFG_DIR_Y:   dir_y_q   <= cfg_wdata_i[gdcr_pkg::VEC_W-1:0];
          gdcr_pkg::CFG_PLANE_X: plane_x_q <= cfg_wdata_i[gdcr_pkg::VEC_W-1:0];
          gdcr_pkg::CFG_PLANE_Y: plane_y_q <= cfg_wdata_i[gdcr_pkg::VEC_W-1:0];
          gdcr_pkg::CFG_WIDTH:   scr_w_q   <= cfg_wdata_i[gdcr_pkg::SCR_W-1:0];
          gdcr_pkg::CFG_HEIGHT:  scr_h_q   <= cfg_wdata_i[gdcr_pkg::SCR_W-1:0];
          default:               scr_h_q   <= scr_h_q;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_quo_q <= div_num;
      div_rem_q <= '0;
      div_den_q <= div_den;
    end else if (div_busy_q) begin
      div_quo_q <= div_quo_n;
      div_rem_q <= div_rem_n;
    end
    case (state_q)
      gdcr_pkg::S_IDLE: begin
        if (in_fire) col_q <= in_col;
        axis_q <= 1'b0;
      end
      gdcr_pkg::S_CAM: begin
        cam_q <= gdcr_pkg::CAM_W'(div_quo_q) - gdcr_pkg::CAM_W'(1 << F);
      end
      gdcr_pkg::S_RAY: begin
        prod_q <= (axis_q ? plane_y_q : plane_x_q) * cam_q;
      end
      gdcr_pkg::S_RD: begin
        if (axis_q) rd_y_q <= rd_sum;
        else rd_x_q <= rd_sum;
        // zero direction: saturate delta and skip the divider
        if (rd_mag == '0) begin
          if (axis_q) dlt_y_q <= gdcr_pkg::DLT_W'(gdcr_pkg::DELTA_SAT);
          else dlt_x_q <= gdcr_pkg::DLT_W'(gdcr_pkg::DELTA_SAT);
        end
      end
      gdcr_pkg::S_DLT: begin
        if (!div_busy_q) begin
          if (axis_q) dlt_y_q <= dlt_clamp;
          else dlt_x_q <= dlt_clamp;
        end
      end
      gdcr_pkg::S_SIDE: begin
        if (axis_q) sd_y_q <= sd_init;
        else sd_x_q <= sd_init;
        axis_q <= 1'b1;
      end
      gdcr_pkg::S_START: begin
        side_q   <= 1'b0;
        left_q   <= start_out;
        perp_q   <= '0;
        iter_q   <= '0;
        cell_x_q <= $signed(CW'(pos_x_q[gdcr_pkg::POS_W-1:F]));
        cell_y_q <= $signed(CW'(pos_y_q[gdcr_pkg::POS_W-1:F]));
      end
      gdcr_pkg::S_STEP: begin
        // advance along the axis whose next side is nearer
        if (sd_x_q < sd_y_q) begin
          sd_x_q   <= sd_x_q + SDW'(dlt_x_q);
          cell_x_q <= rd_x_q[gdcr_pkg::RD_W-1] ? cell_x_q - CW'(1) : cell_x_q + CW'(1);
          side_q   <= 1'b0;
        end else begin
          sd_y_q   <= sd_y_q + SDW'(dlt_y_q);
          cell_y_q <= rd_y_q[gdcr_pkg::RD_W-1] ? cell_y_q - CW'(1) : cell_y_q + CW'(1);
          side_q   <= 1'b1;
        end
        iter_q <= iter_q + IW'(1);
      end
      gdcr_pkg::S_CHK: begin
        if (cell_out) left_q <= 1'b1;
      end
      gdcr_pkg::S_PERP: begin
        perp_q <= side_q ? sd_y_q - SDW'(dlt_y_q) : sd_x_q - SDW'(dlt_x_q);
      end
      gdcr_pkg::S_LINE: begin
        // zero distance: full height line
        line_q <= NW'(h_eff) << F;
      end
      gdcr_pkg::S_LDIV: begin
        if (!div_busy_q) line_q <= div_quo_q;
      end
      gdcr_pkg::S_SPAN: begin
        if (out_free) begin
          out_col_q   <= col_q;
          out_start_q <= gdcr_pkg::COL_W'(span_start);
          out_end_q   <= gdcr_pkg::COL_W'(span_end);
          out_side_q  <= side_q;
          out_left_q  <= left_q;
        end
      end
      default: begin
        axis_q <= axis_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_left_q, out_side_q, out_end_q, out_start_q, out_col_q};

  // Hold off items while the map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gdcr_pkg::S_CLEAR |-> !s_axis_tready_o)
    else $error("item taken during map clearing pass");

  a_div_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy_q)
    else $error("divider launched while busy");

  a_test_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gdcr_pkg::S_TEST |-> !cell_out)
    else $error("map read outside the grid");

  a_result_from_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gdcr_pkg::S_SPAN))
    else $error("result raised outside span stage");

endmodule

[tb/tb_grid_dda_column_raycaster_top.sv]
// Self-checking testbench of the grid DDA column raycaster: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_grid_dda_column_raycaster_top;

  localparam bit      MODE_WRITE  = 1'b0;
  localparam bit      MODE_CAST   = 1'b1;
  localparam int      GRID        = 32;
  localparam int      FRAC_BITS   = gdcr_pkg::FRAC_BITS;
  localparam int      MAX_SCREEN  = gdcr_pkg::MAX_SCREEN;
  localparam int      SETTLE      = 400;
  localparam longint  CYCLE_LIMIT = 2000000;
  localparam int      REPORT_MAX  = 10;

  // Predictor of the column spans and queue of the spans still owed by the block.
  class span_scoreboard;
    logic [7:0]  grid_cells [GRID*GRID];
    logic [20:0] cam_regs [8];
    logic [39:0] owed_spans [$];
    int          mismatches;
    int          casts_seen;
    int          writes_seen;
    int          spans_checked;

    function new();
      foreach (grid_cells[i]) grid_cells[i] = '0;
      cam_regs[gdcr_pkg::CFG_POS_X]   = 21'd98304;
      cam_regs[gdcr_pkg::CFG_POS_Y]   = 21'd98304;
      cam_regs[gdcr_pkg::CFG_DIR_X]   = 21'h3_0000;   // -1.0 in 18 bits
      cam_regs[gdcr_pkg::CFG_DIR_Y]   = 21'd0;
      cam_regs[gdcr_pkg::CFG_PLANE_X] = 21'd0;
      cam_regs[gdcr_pkg::CFG_PLANE_Y] = 21'd43253;
      cam_regs[gdcr_pkg::CFG_WIDTH]   = 21'd640;
      cam_regs[gdcr_pkg::CFG_HEIGHT]  = 21'd480;
      mismatches = 0;
      casts_seen = 0;
      writes_seen = 0;
      spans_checked = 0;
    endfunction

    function void set_reg(gdcr_pkg::cfg_reg_e idx, logic [20:0] v);
      case (idx)
        gdcr_pkg::CFG_POS_X, gdcr_pkg::CFG_POS_Y: cam_regs[idx] = v;
        gdcr_pkg::CFG_WIDTH, gdcr_pkg::CFG_HEIGHT: cam_regs[idx] = {9'd0, v[11:0]};
        default: cam_regs[idx] = {3'd0, v[17:0]};
      endcase
    endfunction

    function longint screen_size(logic [20:0] r);
      longint v;
      v = longint'(r[11:0]);
      if (v == 0) return 1;
      return (v > MAX_SCREEN) ? MAX_SCREEN : v;
    endfunction

    // Cast one column and pack the span as the block does.
    function logic [39:0] cast_column(logic [10:0] col);
      longint w, h, cam, perp, line, half, hh, top, bottom, frac, mag;
      longint pos [2];
      longint dir [2];
      longint pln [2];
      longint rd [2];
      longint dlt [2];
      longint sd [2];
      longint grid_pos [2];
      longint stp [2];
      int     side, left;
      w = screen_size(cam_regs[gdcr_pkg::CFG_WIDTH]);
      h = screen_size(cam_regs[gdcr_pkg::CFG_HEIGHT]);
      pos[0] = longint'(cam_regs[gdcr_pkg::CFG_POS_X]);
      pos[1] = longint'(cam_regs[gdcr_pkg::CFG_POS_Y]);
      dir[0] = longint'($signed(cam_regs[gdcr_pkg::CFG_DIR_X][17:0]));
      dir[1] = longint'($signed(cam_regs[gdcr_pkg::CFG_DIR_Y][17:0]));
      pln[0] = longint'($signed(cam_regs[gdcr_pkg::CFG_PLANE_X][17:0]));
      pln[1] = longint'($signed(cam_regs[gdcr_pkg::CFG_PLANE_Y][17:0]));
      cam = ((longint'(col) * 2) << FRAC_BITS) / w - (longint'(1) << FRAC_BITS);
      side = 0;
      left = 0;
      perp = 0;
      for (int a = 0; a < 2; a++) begin
        frac = pos[a] & ((longint'(1) << FRAC_BITS) - 1);
        rd[a] = dir[a] + ((pln[a] * cam) >>> FRAC_BITS);   // arithmetic shift floors
        mag = (rd[a] < 0) ? -rd[a] : rd[a];
        if (mag == 0) dlt[a] = longint'(1) << (FRAC_BITS + 15);
        else begin
          dlt[a] = (longint'(1) << (2 * FRAC_BITS)) / mag;
          if (dlt[a] > (longint'(1) << (FRAC_BITS + 15)))
            dlt[a] = longint'(1) << (FRAC_BITS + 15);
        end
        grid_pos[a] = pos[a] >> FRAC_BITS;
        if (rd[a] < 0) begin
          stp[a] = -1;
          sd[a] = (frac * dlt[a]) >> FRAC_BITS;
        end else begin
          stp[a] = 1;
          sd[a] = (((longint'(1) << FRAC_BITS) - frac) * dlt[a]) >> FRAC_BITS;
        end
      end
      if (grid_pos[0] >= GRID || grid_pos[1] >= GRID) begin
        left = 1;
      end else begin
        for (int i = 0; i < 2 * GRID + 2; i++) begin
          if (sd[0] < sd[1]) begin
            sd[0] += dlt[0];
            grid_pos[0] += stp[0];
            side = 0;
          end else begin
            sd[1] += dlt[1];
            grid_pos[1] += stp[1];
            side = 1;
          end
          if (grid_pos[0] < 0 || grid_pos[0] >= GRID ||
              grid_pos[1] < 0 || grid_pos[1] >= GRID) begin
            left = 1;
            break;
          end
          if (grid_cells[grid_pos[0] * GRID + grid_pos[1]] != 0) break;
        end
        perp = sd[side] - dlt[side];
      end
      line = (perp == 0) ? (h << FRAC_BITS) : (h << FRAC_BITS) / perp;
      half = line / 2;
      hh = h / 2;
      top = (half >= hh) ? 0 : hh - half;
      bottom = hh + half;
      if (bottom > h - 1) bottom = h - 1;
      return {5'd0, left[0], side[0], bottom[10:0], top[10:0], col};
    endfunction

    function void note_input(bit mode, logic [31:0] d);
      if (mode == MODE_WRITE) begin
        grid_cells[d[15:11] * GRID + d[20:16]] = d[28:21];
        writes_seen++;
      end else begin
        owed_spans.push_back(cast_column(d[10:0]));
        casts_seen++;
      end
    endfunction

    function void check_result(logic [39:0] got);
      logic [39:0] want;
      if (owed_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected span %h with nothing owed", got);
        return;
      end
      want = owed_spans.pop_front();
      spans_checked++;
      if (got[10:0] !== want[10:0] || got[21:11] !== want[21:11] ||
          got[32:22] !== want[32:22] || got[33] !== want[33] || got[34] !== want[34]) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display({"ERROR: col exp %0d got %0d, start exp %0d got %0d, ",
                    "end exp %0d got %0d, side exp %0d got %0d, left exp %0d got %0d"},
                   want[10:0], got[10:0], want[21:11], got[21:11], want[32:22], got[32:22],
                   want[33], got[33], want[34], got[34]);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [20:0] cfg_wdata_i;

  span_scoreboard spans;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     recv_hold_left;
  longint cycle_count;

  grid_dda_column_raycaster_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 20 ns clock.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick tready for the next edge.
  // A long hold-off is counted down here while the sender keeps offering items.
  initial begin
    m_axis_tready_i = 1'b0;
    recv_hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) spans.check_result(m_axis_tdata_o);
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item and hold it until the transaction completes; tvalid stays high after.
  task automatic send_item(bit mode, logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    spans.note_input(mode, d);
  endtask

  function automatic logic [31:0] cell_item(logic [4:0] cx, logic [4:0] cy, logic [7:0] v);
    return {3'd0, v, cy, cx, 11'd0};
  endfunction

  function automatic logic [31:0] cast_item(logic [10:0] col);
    // Unused cell fields carry random bits; the block must ignore them.
    return {3'd0, 18'($urandom()), col};
  endfunction

  // Write one register; cfg_valid stays high so back-to-back writes do not toggle it.
  task automatic write_reg(gdcr_pkg::cfg_reg_e idx, logic [20:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    spans.set_reg(idx, v);
  endtask

  task automatic end_cfg();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop tvalid, wait for every owed span, then let the block settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (spans.owed_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_camera(logic [20:0] px, logic [20:0] py, logic [17:0] dx, logic [17:0] dy,
                             logic [17:0] plx, logic [17:0] ply, logic [11:0] w, logic [11:0] h);
    write_reg(gdcr_pkg::CFG_POS_X, px);
    write_reg(gdcr_pkg::CFG_POS_Y, py);
    write_reg(gdcr_pkg::CFG_DIR_X, {3'd0, dx});
    write_reg(gdcr_pkg::CFG_DIR_Y, {3'd0, dy});
    write_reg(gdcr_pkg::CFG_PLANE_X, {3'd0, plx});
    write_reg(gdcr_pkg::CFG_PLANE_Y, {3'd0, ply});
    write_reg(gdcr_pkg::CFG_WIDTH, {9'd0, w});
    write_reg(gdcr_pkg::CFG_HEIGHT, {9'd0, h});
    end_cfg();
  endtask

  // Random camera: mostly sane screens and unit-ish vectors, sometimes the raw extremes.
  task automatic random_camera();
    logic [17:0] vec [4];
    logic [11:0] w, h;
    foreach (vec[i])
      vec[i] = ($urandom_range(3) == 0) ? 18'($urandom()) :
               18'($signed($urandom_range(0, 196608)) - 98304);
    w = ($urandom_range(5) == 0) ? 12'($urandom()) : 12'($urandom_range(1, 2048));
    h = ($urandom_range(5) == 0) ? 12'($urandom()) : 12'($urandom_range(1, 2048));
    load_camera(21'($urandom()), 21'($urandom()), vec[0], vec[1], vec[2], vec[3], w, h);
  endtask

  int ncols;
  int phase_len;

  initial begin
    spans = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = MODE_WRITE;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = gdcr_pkg::CFG_POS_X;
    cfg_wdata_i     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty map with the reset camera, so every ray leaves the map.
    send_item(MODE_CAST, cast_item(11'd0));
    send_item(MODE_CAST, cast_item(11'd639));
    send_item(MODE_CAST, cast_item(11'd2047));   // column far past the width
    // Walls at the corners and edges of the field values.
    send_item(MODE_WRITE, cell_item(5'd0, 5'd1, 8'hFF));
    send_item(MODE_WRITE, cell_item(5'd1, 5'd0, 8'h01));
    send_item(MODE_WRITE, cell_item(5'd31, 5'd31, 8'h80));
    send_item(MODE_WRITE, cell_item(5'd2, 5'd3, 8'h7F));
    send_item(MODE_WRITE, cell_item(5'd0, 5'd1, 8'h00));   // clear it again
    send_item(MODE_CAST, cast_item(11'd0));
    send_item(MODE_CAST, cast_item(11'd320));
    send_item(MODE_CAST, cast_item(11'd639));
    drain();

    // Zero distance: camera on a cell corner, looking straight at the next wall;
    // zero screen sizes are taken as one.
    load_camera(21'd196608, 21'd196608, 18'h3_0000, 18'd0, 18'd0, 18'd0, 12'd0, 12'd0);
    send_item(MODE_CAST, cast_item(11'd0));
    send_item(MODE_CAST, cast_item(11'd5));
    drain();

    // Zero direction on both axes, oversized screen, camera at the far corner.
    load_camera(21'h1F_FFFF, 21'h1F_FFFF, 18'd0, 18'd0, 18'd0, 18'd0, 12'hFFF, 12'hFFF);
    send_item(MODE_CAST, cast_item(11'd1024));
    drain();

    // Vector extremes.
    load_camera(21'd0, 21'd0, 18'h2_0000, 18'h1_FFFF, 18'h1_FFFF, 18'h2_0000, 12'd2048, 12'd2048);
    send_item(MODE_CAST, cast_item(11'd0));
    send_item(MODE_CAST, cast_item(11'd2047));
    drain();
    load_camera(21'd1048576, 21'd1048576, 18'h1_FFFF, 18'h2_0000, 18'h2_0000, 18'h1_FFFF,
                12'd1, 12'd1);
    send_item(MODE_CAST, cast_item(11'd0));
    send_item(MODE_CAST, cast_item(11'd1));
    drain();

    // Random phases: each idling pattern twice, with a fresh camera each time.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      random_camera();
      ncols = (spans.cam_regs[gdcr_pkg::CFG_WIDTH][11:0] == 0) ? 1 :
              spans.cam_regs[gdcr_pkg::CFG_WIDTH][11:0];
      if (ncols > 2048) ncols = 2048;
      phase_len = 66;
      // Long receiver hold-off so the block backs up and stalls its input.
      if (ph == 0) recv_hold_left = 600;
      for (int n = 0; n < phase_len; n++) begin
        // Sender pause until every owed span has come back.
        if (ph == 4 && n == phase_len / 2) begin
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
          while (spans.owed_spans.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(99) < 35)
          send_item(MODE_WRITE, cell_item(5'($urandom()), 5'($urandom()),
                    ($urandom_range(99) < 65) ? 8'($urandom_range(1, 255)) : 8'd0));
        else if ($urandom_range(9) == 0)
          send_item(MODE_CAST, cast_item(11'($urandom())));
        else
          send_item(MODE_CAST, cast_item(11'($urandom_range(0, ncols - 1))));
      end
      drain();
    end

    while (spans.owed_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (spans.owed_spans.size() != 0) spans.mismatches++;
    $display("Run covered %0d casts and %0d cell writes over 13 camera settings,",
             spans.casts_seen, spans.writes_seen);
    $display("with %0d spans checked under four idling patterns, %0d mismatches.",
             spans.spans_checked, spans.mismatches);
    if (spans.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
design/gdcr_pkg.sv
design/grid_dda_column_raycaster_top.sv
tb/tb_grid_dda_column_raycaster_top.sv
